@@ hw/rtl/byte_ring_buffer_macros.svh @@
// assertion macros for the byte ring buffer
// used by the modules that carry assertions, expects clock and reset in scope
`ifndef BYTE_RING_BUFFER_MACROS_SVH
`define BYTE_RING_BUFFER_MACROS_SVH

// property that must hold in the same cycle as its trigger
`define BRB_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// property that must hold in the cycle after its trigger
`define BRB_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/brb_pkg.sv @@
// shared types and constants of the byte ring buffer
// no dependencies
package brb_pkg;

   localparam int CNT_W      = 11;
   localparam int COUNT_W    = 4;
   localparam int DATA_W     = 64;
   localparam int BYTE_W     = 8;
   localparam int BYTE_IDX_W = 3;
   localparam int REQ_DATA_W = 72;
   localparam int RSP_DATA_W = 96;

   localparam int DEPTH_DEFAULT = 1024;
   localparam int CAP_RESET     = 1024;

   localparam logic [COUNT_W-1:0] MAX_BYTES = 4'd8;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_READ  = 1'b1;

   localparam logic STATUS_DONE    = 1'b0;
   localparam logic STATUS_REFUSED = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SETUP,
      ST_LOOP,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic cfg_write;
      logic load;
      logic setup;
      logic step;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic rem_zero;
      logic out_busy;
   } stat_type;

endpackage

@@ hw/rtl/brb_ctrl.sv @@
// controller state machine of the byte ring buffer
// depends on brb_pkg
module brb_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  brb_pkg::stat_type stat,
   output brb_pkg::cmd_type  cmd
);

   brb_pkg::state_type state_ff;
   brb_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= brb_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         brb_pkg::ST_IDLE: begin
            if (req_tvalid && !csr_valid) begin
               state_in = brb_pkg::ST_SETUP;
            end
         end
         brb_pkg::ST_SETUP: begin
            state_in = brb_pkg::ST_LOOP;
         end
         brb_pkg::ST_LOOP: begin
            if (stat.rem_zero) begin
               state_in = brb_pkg::ST_FINISH;
            end
         end
         brb_pkg::ST_FINISH: begin
            if (!stat.out_busy) begin
               state_in = brb_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = brb_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_tready    = 1'b0;
      csr_ready     = 1'b0;
      cmd           = '0;
      unique case (state_ff)
         brb_pkg::ST_IDLE: begin
            csr_ready     = 1'b1;
            req_tready    = !csr_valid;
            cmd.cfg_write = csr_valid;
            cmd.load      = req_tvalid && !csr_valid;
         end
         brb_pkg::ST_SETUP: begin
            cmd.setup = 1'b1;
         end
         brb_pkg::ST_LOOP: begin
            cmd.step = !stat.rem_zero;
         end
         brb_pkg::ST_FINISH: begin
            cmd.finish = !stat.out_busy;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

@@ hw/rtl/brb_datapath.sv @@
// datapath of the byte ring buffer: byte store, pointers, count and result register
// depends on brb_pkg and byte_ring_buffer_macros.svh
`include "byte_ring_buffer_macros.svh"

module brb_datapath #(
   parameter int DEPTH = brb_pkg::DEPTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  brb_pkg::cmd_type              cmd,
   output brb_pkg::stat_type             stat,
   input  logic [brb_pkg::CNT_W-1:0]     csr_data,
   input  logic                          req_op,
   input  logic [brb_pkg::COUNT_W-1:0]   req_count,
   input  logic [brb_pkg::DATA_W-1:0]    req_wdata,
   input  logic                          rsp_tready,
   output logic                          rsp_tvalid,
   output logic                          rsp_status,
   output logic [brb_pkg::COUNT_W-1:0]   rsp_moved,
   output logic [brb_pkg::DATA_W-1:0]    rsp_rdata,
   output logic [brb_pkg::CNT_W-1:0]     rsp_occupancy,
   output logic [brb_pkg::CNT_W-1:0]     rsp_free
);

   localparam int CNT_W   = brb_pkg::CNT_W;
   localparam int COUNT_W = brb_pkg::COUNT_W;
   localparam int DATA_W  = brb_pkg::DATA_W;
   localparam int BYTE_W  = brb_pkg::BYTE_W;
   localparam int BIDX_W  = brb_pkg::BYTE_IDX_W;
   localparam int PTR_W   = $clog2(DEPTH);
   localparam int SUM_W   = ((PTR_W > CNT_W) ? PTR_W : CNT_W) + 1;
   localparam logic [CNT_W-1:0] CAP_INIT =
      (DEPTH < brb_pkg::CAP_RESET) ? CNT_W'(DEPTH) : CNT_W'(brb_pkg::CAP_RESET);

   logic [BYTE_W-1:0] mem [DEPTH];

   logic [CNT_W-1:0]   cap_ff, cap_in;
   logic [PTR_W-1:0]   ptr_ff, ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [PTR_W-1:0]   idx_ff, idx_in;
   logic [COUNT_W-1:0] rem_ff, rem_in;
   logic               rd_pend_ff, rd_pend_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic                op_ff, op_in;
   logic [COUNT_W-1:0]  req_ff, req_in;
   logic [DATA_W-1:0]   wdata_ff, wdata_in;
   logic [DATA_W-1:0]   rdata_ff, rdata_in;
   logic [BIDX_W-1:0]   cidx_ff, cidx_in;
   logic                status_ff, status_in;
   logic [COUNT_W-1:0]  moved_ff, moved_in;
   logic [BYTE_W-1:0]   mem_q_ff;

   logic                out_status_ff, out_status_in;
   logic [COUNT_W-1:0]  out_moved_ff, out_moved_in;
   logic [DATA_W-1:0]   out_rdata_ff, out_rdata_in;
   logic [CNT_W-1:0]    out_occ_ff, out_occ_in;
   logic [CNT_W-1:0]    out_free_ff, out_free_in;

   logic [CNT_W-1:0]    free_now;
   logic [CNT_W-1:0]    avail;
   logic                refused;
   logic [COUNT_W-1:0]  moved_calc;
   logic [SUM_W-1:0]    tail_sum;
   logic [SUM_W-1:0]    tail_wrap;
   logic [PTR_W-1:0]    idx_start;
   logic [PTR_W-1:0]    idx_next;
   logic [CNT_W-1:0]    count_upd;
   logic [CNT_W-1:0]    cap_clamp;
   logic                mem_we;

   always_comb begin
      free_now  = cap_ff - count_ff;
      avail     = (op_ff == brb_pkg::OP_WRITE) ? free_now : count_ff;
      refused   = (req_ff != '0) && (avail == '0);
      if (refused) begin
         moved_calc = '0;
      end else if (CNT_W'(req_ff) < avail) begin
         moved_calc = req_ff;
      end else begin
         moved_calc = avail[COUNT_W-1:0];
      end
      tail_sum  = SUM_W'(ptr_ff) + SUM_W'(count_ff);
      tail_wrap = (tail_sum >= SUM_W'(cap_ff)) ? tail_sum - SUM_W'(cap_ff) : tail_sum;
      idx_start = (op_ff == brb_pkg::OP_WRITE) ? tail_wrap[PTR_W-1:0] : ptr_ff;
      idx_next  = ((SUM_W'(idx_ff) + SUM_W'(1)) == SUM_W'(cap_ff)) ? '0
                                                                   : idx_ff + PTR_W'(1);
      count_upd = (op_ff == brb_pkg::OP_WRITE) ? count_ff + CNT_W'(moved_ff)
                                               : count_ff - CNT_W'(moved_ff);
      if (csr_data == '0) begin
         cap_clamp = CNT_W'(1);
      end else if (32'(csr_data) > 32'(DEPTH)) begin
         cap_clamp = CNT_W'(DEPTH);
      end else begin
         cap_clamp = csr_data;
      end
      mem_we = cmd.step && (op_ff == brb_pkg::OP_WRITE);
   end

   always_comb begin
      cap_in       = cap_ff;
      ptr_in       = ptr_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      rem_in       = rem_ff;
      rd_pend_in   = cmd.step && (op_ff == brb_pkg::OP_READ);
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      op_in        = op_ff;
      req_in       = req_ff;
      wdata_in     = wdata_ff;
      rdata_in     = rdata_ff;
      cidx_in      = cidx_ff;
      status_in    = status_ff;
      moved_in     = moved_ff;
      out_status_in = out_status_ff;
      out_moved_in  = out_moved_ff;
      out_rdata_in  = out_rdata_ff;
      out_occ_in    = out_occ_ff;
      out_free_in   = out_free_ff;
      if (cmd.cfg_write) begin
         cap_in   = cap_clamp;
         ptr_in   = '0;
         count_in = '0;
      end
      if (cmd.load) begin
         op_in    = req_op;
         req_in   = (req_count > brb_pkg::MAX_BYTES) ? brb_pkg::MAX_BYTES : req_count;
         wdata_in = req_wdata;
      end
      if (cmd.setup) begin
         status_in = refused ? brb_pkg::STATUS_REFUSED : brb_pkg::STATUS_DONE;
         moved_in  = moved_calc;
         rem_in    = moved_calc;
         idx_in    = idx_start;
         cidx_in   = '0;
         rdata_in  = '0;
      end
      if (cmd.step) begin
         idx_in   = idx_next;
         rem_in   = rem_ff - COUNT_W'(1);
         wdata_in = wdata_ff >> BYTE_W;
      end
      if (rd_pend_ff) begin
         rdata_in[{cidx_ff, 3'b000} +: BYTE_W] = mem_q_ff;
         cidx_in = cidx_ff + BIDX_W'(1);
      end
      if (cmd.finish) begin
         count_in      = count_upd;
         if (op_ff == brb_pkg::OP_READ) begin
            ptr_in = idx_ff;
         end
         rsp_valid_in  = 1'b1;
         out_status_in = status_ff;
         out_moved_in  = moved_ff;
         out_rdata_in  = rdata_ff;
         out_occ_in    = count_upd;
         out_free_in   = cap_ff - count_upd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= CAP_INIT;
         ptr_ff       <= '0;
         count_ff     <= '0;
         rem_ff       <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cap_ff       <= cap_in;
         ptr_ff       <= ptr_in;
         count_ff     <= count_in;
         rem_ff       <= rem_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      op_ff         <= op_in;
      req_ff        <= req_in;
      wdata_ff      <= wdata_in;
      rdata_ff      <= rdata_in;
      cidx_ff       <= cidx_in;
      status_ff     <= status_in;
      moved_ff      <= moved_in;
      out_status_ff <= out_status_in;
      out_moved_ff  <= out_moved_in;
      out_rdata_ff  <= out_rdata_in;
      out_occ_ff    <= out_occ_in;
      out_free_ff   <= out_free_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[idx_ff] <= wdata_ff[BYTE_W-1:0];
      end
      mem_q_ff <= mem[idx_ff];
   end

   assign stat.rem_zero  = (rem_ff == '0);
   assign stat.out_busy  = rsp_valid_ff && !rsp_tready;

   assign rsp_tvalid    = rsp_valid_ff;
   assign rsp_status    = out_status_ff;
   assign rsp_moved     = out_moved_ff;
   assign rsp_rdata     = out_rdata_ff;
   assign rsp_occupancy = out_occ_ff;
   assign rsp_free      = out_free_ff;

   `BRB_ASSERT_NOW(a_count_in_cap, 1'b1, count_ff <= cap_ff, "stored count exceeds capacity")
   `BRB_ASSERT_NOW(a_ptr_in_cap, 1'b1, SUM_W'(ptr_ff) < SUM_W'(cap_ff),
                   "read pointer outside capacity")
   `BRB_ASSERT_NOW(a_rem_bounded, 1'b1, rem_ff <= brb_pkg::MAX_BYTES,
                   "byte loop count above limit")
   `BRB_ASSERT_NEXT(a_refused_moves_none, cmd.finish && status_ff == brb_pkg::STATUS_REFUSED,
                    rsp_moved == '0 && rsp_rdata == '0, "refused transfer moved bytes")

endmodule

@@ hw/rtl/byte_ring_buffer.sv @@
// byte ring buffer top level
// usage: req channel carries write or read requests of up to eight bytes, one result
// per request on rsp; csr channel writes the capacity and empties the buffer.
// each request is handled one byte per cycle through the single byte-wide store port:
// rsp_tvalid rises after the request transfer has passed through the setup step, one
// loop step per byte written or read (0 to 8) and the finish step; a new request is
// taken only once the block is back in idle, not while the previous one is in progress.
// the result sits in an output register: while rsp_tready is low the next request is
// still taken and processed, and the block holds in its last step until the register
// frees up.
// csr_ready is high whenever no request is in progress; a capacity write takes priority
// over a request offered in the same cycle. capacity 0 acts as 1, above DEPTH as DEPTH.
// reset empties the buffer and sets the capacity to 1024 (or DEPTH if smaller); the
// store itself is not cleared and no clearing pass is needed.
// depends on brb_pkg, brb_ctrl and brb_datapath
module byte_ring_buffer #(
   parameter int DEPTH = brb_pkg::DEPTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [brb_pkg::REQ_DATA_W-1:0]    req_tdata,   // byte_count, write_data, pad
   input  logic [0:0]                        req_tuser,   // operation
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [brb_pkg::RSP_DATA_W-1:0]    rsp_tdata,   // moved_count, read_data,
                                                          // occupancy, space_left, pad
   output logic [0:0]                        rsp_tuser,   // status
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [brb_pkg::CNT_W-1:0]         csr_data     // capacity
);

   localparam int CNT_W   = brb_pkg::CNT_W;
   localparam int COUNT_W = brb_pkg::COUNT_W;
   localparam int DATA_W  = brb_pkg::DATA_W;
   localparam int USED_W  = COUNT_W + DATA_W + 2 * CNT_W;

   brb_pkg::cmd_type  cmd;
   brb_pkg::stat_type stat;

   logic [COUNT_W-1:0] rsp_moved;
   logic [DATA_W-1:0]  rsp_rdata;
   logic [CNT_W-1:0]   rsp_occupancy;
   logic [CNT_W-1:0]   rsp_free;
   logic               rsp_status;

   brb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .stat       (stat),
      .cmd        (cmd)
   );

   brb_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .csr_data      (csr_data),
      .req_op        (req_tuser[0]),
      .req_count     (req_tdata[COUNT_W-1:0]),
      .req_wdata     (req_tdata[COUNT_W+DATA_W-1:COUNT_W]),
      .rsp_tready    (rsp_tready),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_status    (rsp_status),
      .rsp_moved     (rsp_moved),
      .rsp_rdata     (rsp_rdata),
      .rsp_occupancy (rsp_occupancy),
      .rsp_free      (rsp_free)
   );

   assign rsp_tdata = {{(brb_pkg::RSP_DATA_W - USED_W){1'b0}},
                       rsp_free, rsp_occupancy, rsp_rdata, rsp_moved};
   assign rsp_tuser = rsp_status;

endmodule
